>>> sv/tcph_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TCP handshake engine.
package tcph_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned FlagW = 2;

  localparam logic [PortW-1:0] LocalPortReset = 16'd5678;

  localparam logic [FlagW-1:0] FlNone   = 2'b00;
  localparam logic [FlagW-1:0] FlSyn    = 2'b01;
  localparam logic [FlagW-1:0] FlAck    = 2'b10;
  localparam logic [FlagW-1:0] FlSynAck = 2'b11;

  typedef enum logic [1:0] {
    ACT_LISTEN  = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_SEGMENT = 2'd2,
    ACT_TIMEOUT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_CLOSED      = 3'd0,
    PH_LISTEN      = 3'd1,
    PH_SYN_SENT    = 3'd2,
    PH_SYN_RECV    = 3'd3,
    PH_ESTABLISHED = 3'd4
  } phase_t;

  typedef struct packed {
    action_t            action;
    logic [FlagW-1:0]   seg_flags;
    logic [SeqW-1:0]    seg_seq;
    logic [SeqW-1:0]    seg_ack;
    logic [PortW-1:0]   peer_port;
    logic [SeqW-1:0]    new_isn;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic [SeqW-1:0]    send_initial;
    logic [SeqW-1:0]    send_unacked;
    logic [SeqW-1:0]    send_next;
    logic [SeqW-1:0]    recv_initial;
    logic [SeqW-1:0]    recv_next;
    logic [PortW-1:0]   remote_port;
    logic               syn_resent;
  } conn_t;

  typedef struct packed {
    logic               send_valid;
    logic [FlagW-1:0]   flags;
    logic [SeqW-1:0]    seq;
    logic [SeqW-1:0]    ack;
    logic [PortW-1:0]   dst_port;
    phase_t             conn_state;
    logic               became_established;
  } result_t;

endpackage

>>> sv/tcp_handshake_engine_top.sv
`timescale 1ns / 1ps
// Top level of the TCP handshake engine: input register, step logic, result register.
// A beat accepted into the input register reaches the outputs through the result register.
// Throughput: one beat per cycle unless out_stall holds a full result register; the
// connection state updates as a beat leaves the input register, so the next beat sees it.
// Reset: phase closed, sequence numbers and peer port zero, local_port 5678,
// both pipeline registers empty.
module tcp_handshake_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcph_pkg::PortW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [tcph_pkg::FlagW-1:0]  seg_flags,
  input  logic [tcph_pkg::SeqW-1:0]   seg_seq,
  input  logic [tcph_pkg::SeqW-1:0]   seg_ack,
  input  logic [tcph_pkg::PortW-1:0]  peer_port,
  input  logic [tcph_pkg::SeqW-1:0]   new_isn,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        send_valid,
  output logic [tcph_pkg::FlagW-1:0]  out_flags,
  output logic [tcph_pkg::SeqW-1:0]   out_seq,
  output logic [tcph_pkg::SeqW-1:0]   out_ack,
  output logic [tcph_pkg::PortW-1:0]  out_dst_port,
  output logic [2:0]                  conn_state,
  output logic                        became_established
);

  logic [tcph_pkg::PortW-1:0] local_port;
  logic                       item_valid;
  tcph_pkg::item_t            item;
  tcph_pkg::conn_t            conn;
  tcph_pkg::conn_t            conn_next;
  tcph_pkg::result_t          step_result;
  tcph_pkg::result_t          result;
  logic                       advance;

  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && out_valid && out_stall;
  assign cfg_ready = !item_valid;

  tcph_step u_step (
    .item      (item),
    .conn      (conn),
    .conn_next (conn_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      local_port <= tcph_pkg::LocalPortReset;
    end else if (cfg_valid && cfg_ready) begin
      local_port <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.action    <= tcph_pkg::action_t'(action);
      item.seg_flags <= seg_flags;
      item.seg_seq   <= seg_seq;
      item.seg_ack   <= seg_ack;
      item.peer_port <= peer_port;
      item.new_isn   <= new_isn;
    end
  end

  // connection state; all-zero is phase closed
  always_ff @(posedge clk) begin
    if (rst) begin
      conn <= '0;
    end else if (advance) begin
      conn <= conn_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign send_valid         = result.send_valid;
  assign out_flags          = result.flags;
  assign out_seq            = result.seq;
  assign out_ack            = result.ack;
  assign out_dst_port       = result.dst_port;
  assign conn_state         = result.conn_state;
  assign became_established = result.became_established;

  a_done_means_established: assert property (@(posedge clk) disable iff (rst)
    out_valid && became_established |-> conn_state == tcph_pkg::PH_ESTABLISHED)
    else $error("handshake completion without established state");

  a_quiet_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_valid |-> out_flags == tcph_pkg::FlNone && out_seq == '0 &&
                                 out_ack == '0 && out_dst_port == '0)
    else $error("segment fields nonzero with no segment to send");

  a_bare_syn_no_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_valid && out_flags == tcph_pkg::FlSyn |-> out_ack == '0)
    else $error("bare SYN carries an acknowledgement");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(conn))
    else $error("connection state changed without a beat advancing");

  a_reset_closed: assert property (@(posedge clk)
    $past(rst) |-> conn.phase == tcph_pkg::PH_CLOSED && !item_valid && !out_valid)
    else $error("reset did not close the connection");

endmodule

>>> sv/tcph_step.sv
`timescale 1ns / 1ps
// Handshake step logic: next connection state and control segment for one item.
module tcph_step (
  input  tcph_pkg::item_t   item,
  input  tcph_pkg::conn_t   conn,
  output tcph_pkg::conn_t   conn_next,
  output tcph_pkg::result_t result
);

  logic syn;
  logic ackf;
  logic is_seg;
  logic synack_ok;
  logic dup_synack;
  logic dup_syn;
  logic final_ack;
  logic passive_syn;
  logic [tcph_pkg::SeqW-1:0] isn_plus1;
  logic [tcph_pkg::SeqW-1:0] seq_plus1;
  tcph_pkg::phase_t phase_next;
  logic done;

  assign syn    = item.seg_flags[0];
  assign ackf   = item.seg_flags[1];
  assign is_seg = (item.action == tcph_pkg::ACT_SEGMENT);

  assign isn_plus1 = item.new_isn + tcph_pkg::SeqW'(1);
  assign seq_plus1 = item.seg_seq + tcph_pkg::SeqW'(1);

  assign synack_ok   = is_seg && conn.phase == tcph_pkg::PH_SYN_SENT && syn && ackf &&
                       item.seg_ack == conn.send_next;
  assign dup_synack  = is_seg && conn.phase == tcph_pkg::PH_ESTABLISHED && syn && ackf &&
                       item.seg_seq == conn.recv_initial && item.seg_ack == conn.send_next;
  assign dup_syn     = is_seg && conn.phase == tcph_pkg::PH_SYN_RECV && syn && !ackf &&
                       item.seg_seq == conn.recv_initial;
  assign final_ack   = is_seg && conn.phase == tcph_pkg::PH_SYN_RECV && ackf && !syn &&
                       item.seg_ack == conn.send_next && item.seg_seq == conn.recv_next;
  assign passive_syn = is_seg && conn.phase == tcph_pkg::PH_LISTEN && syn && !ackf;

  // next phase
  always_comb begin
    phase_next = conn.phase;
    done       = 1'b0;
    case (item.action)
      tcph_pkg::ACT_LISTEN:  phase_next = tcph_pkg::PH_LISTEN;
      tcph_pkg::ACT_CONNECT: phase_next = tcph_pkg::PH_SYN_SENT;
      tcph_pkg::ACT_SEGMENT: begin
        if (synack_ok || final_ack) begin
          phase_next = tcph_pkg::PH_ESTABLISHED;
          done       = 1'b1;
        end else if (passive_syn) begin
          phase_next = tcph_pkg::PH_SYN_RECV;
        end
      end
      default: ;
    endcase
  end

  // sequence state and outgoing segment
  always_comb begin
    conn_next        = conn;
    conn_next.phase  = phase_next;
    result           = '0;
    case (item.action)
      tcph_pkg::ACT_CONNECT: begin
        conn_next.remote_port  = item.peer_port;
        conn_next.send_initial = item.new_isn;
        conn_next.send_unacked = item.new_isn;
        conn_next.send_next    = isn_plus1;
        result.send_valid      = 1'b1;
        result.flags           = tcph_pkg::FlSyn;
        result.seq             = item.new_isn;
        result.dst_port        = item.peer_port;
      end
      tcph_pkg::ACT_SEGMENT: begin
        if (synack_ok) begin
          conn_next.recv_initial = item.seg_seq;
          conn_next.recv_next    = seq_plus1;
          conn_next.send_unacked = item.seg_ack;
          result.send_valid      = 1'b1;
          result.flags           = tcph_pkg::FlAck;
          result.seq             = conn.send_next;
          result.ack             = seq_plus1;
          result.dst_port        = conn.remote_port;
        end else if (dup_synack) begin
          result.send_valid = 1'b1;
          result.flags      = tcph_pkg::FlAck;
          result.seq        = conn.send_next;
          result.ack        = conn.recv_next;
          result.dst_port   = conn.remote_port;
        end else if (dup_syn) begin
          result.send_valid = 1'b1;
          result.flags      = tcph_pkg::FlSynAck;
          result.seq        = conn.send_initial;
          result.ack        = conn.recv_next;
          result.dst_port   = conn.remote_port;
        end else if (final_ack) begin
          conn_next.send_unacked = item.seg_ack;
        end else if (passive_syn) begin
          conn_next.remote_port  = item.peer_port;
          conn_next.recv_initial = item.seg_seq;
          conn_next.recv_next    = seq_plus1;
          conn_next.send_initial = item.new_isn;
          conn_next.send_unacked = item.new_isn;
          conn_next.send_next    = isn_plus1;
          conn_next.syn_resent   = 1'b0;
          result.send_valid      = 1'b1;
          result.flags           = tcph_pkg::FlSynAck;
          result.seq             = item.new_isn;
          result.ack             = seq_plus1;
          result.dst_port        = item.peer_port;
        end
      end
      tcph_pkg::ACT_TIMEOUT: begin
        if (conn.phase == tcph_pkg::PH_SYN_SENT) begin
          conn_next.syn_resent = 1'b1;
          result.send_valid    = 1'b1;
          result.flags         = tcph_pkg::FlSyn;
          result.seq           = conn.send_initial;
          result.dst_port      = conn.remote_port;
        end else if (conn.phase == tcph_pkg::PH_SYN_RECV) begin
          result.send_valid = 1'b1;
          result.flags      = tcph_pkg::FlSynAck;
          result.seq        = conn.send_initial;
          result.ack        = conn.recv_next;
          result.dst_port   = conn.remote_port;
        end
      end
      default: ;
    endcase
    result.conn_state         = phase_next;
    result.became_established = done;
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for tcp_handshake_engine_top: handshake sessions, scoreboard and self-check.
import tcph_pkg::*;

class handshake_tracker;
  phase_t           cur_phase;
  logic [SeqW-1:0]  snd_isn;
  logic [SeqW-1:0]  snd_una;
  logic [SeqW-1:0]  snd_nxt;
  logic [SeqW-1:0]  rcv_isn;
  logic [SeqW-1:0]  rcv_nxt;
  logic [PortW-1:0] peer;
  logic             syn_again;
  logic [PortW-1:0] src_port;
  result_t          replies_due[$];
  int               mismatches;

  function new();
    cur_phase  = PH_CLOSED;
    snd_isn    = '0;
    snd_una    = '0;
    snd_nxt    = '0;
    rcv_isn    = '0;
    rcv_nxt    = '0;
    peer       = '0;
    syn_again  = 1'b0;
    src_port   = LocalPortReset;
    mismatches = 0;
  endfunction

  function void set_src_port(logic [PortW-1:0] v);
    src_port = v;
  endfunction

  function int backlog();
    return replies_due.size();
  endfunction

  function result_t segment(logic [FlagW-1:0] fl, logic [SeqW-1:0] sq, logic [SeqW-1:0] ak);
    result_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.flags      = fl;
    r.seq        = sq;
    r.ack        = ak;
    r.dst_port   = peer;
    return r;
  endfunction

  // next connection state and the reply for one accepted beat
  function void note_item(item_t it);
    result_t r;
    logic    syn_f;
    logic    ack_f;
    logic    done;
    r     = '0;
    syn_f = |(it.seg_flags & FlSyn);
    ack_f = |(it.seg_flags & FlAck);
    done  = 1'b0;
    case (it.action)
      ACT_LISTEN: begin
        cur_phase = PH_LISTEN;
      end
      ACT_CONNECT: begin
        peer      = it.peer_port;
        snd_isn   = it.new_isn;
        snd_una   = it.new_isn;
        snd_nxt   = it.new_isn + 32'd1;
        cur_phase = PH_SYN_SENT;
        r = segment(FlSyn, snd_isn, '0);
      end
      ACT_SEGMENT: begin
        if (cur_phase == PH_SYN_SENT && syn_f && ack_f) begin
          if (it.seg_ack == snd_nxt) begin
            rcv_isn   = it.seg_seq;
            rcv_nxt   = it.seg_seq + 32'd1;
            snd_una   = it.seg_ack;
            r = segment(FlAck, snd_nxt, rcv_nxt);
            cur_phase = PH_ESTABLISHED;
            done      = 1'b1;
          end
        end else if (cur_phase == PH_ESTABLISHED && syn_f && ack_f) begin
          if (it.seg_seq == rcv_isn && it.seg_ack == snd_nxt)
            r = segment(FlAck, snd_nxt, rcv_nxt);
        end else if (cur_phase == PH_SYN_RECV && syn_f && !ack_f) begin
          if (it.seg_seq == rcv_isn)
            r = segment(FlSynAck, snd_isn, rcv_nxt);
        end else if (cur_phase == PH_SYN_RECV && ack_f && !syn_f) begin
          if (it.seg_ack == snd_nxt && it.seg_seq == rcv_nxt) begin
            snd_una   = it.seg_ack;
            cur_phase = PH_ESTABLISHED;
            done      = 1'b1;
          end
        end else if (cur_phase == PH_LISTEN && syn_f && !ack_f) begin
          peer      = it.peer_port;
          rcv_isn   = it.seg_seq;
          rcv_nxt   = it.seg_seq + 32'd1;
          snd_isn   = it.new_isn;
          snd_una   = it.new_isn;
          snd_nxt   = it.new_isn + 32'd1;
          syn_again = 1'b0;
          cur_phase = PH_SYN_RECV;
          r = segment(FlSynAck, snd_isn, rcv_nxt);
        end
      end
      default: begin
        if (cur_phase == PH_SYN_SENT) begin
          syn_again = 1'b1;
          r = segment(FlSyn, snd_isn, '0);
        end else if (cur_phase == PH_SYN_RECV) begin
          r = segment(FlSynAck, snd_isn, rcv_nxt);
        end
      end
    endcase
    r.conn_state         = cur_phase;
    r.became_established = done;
    replies_due.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    string   bad;
    bad = "";
    if (replies_due.size() == 0) begin
      want = '0;
      bad  = " unexpected";
    end else begin
      want = replies_due.pop_front();
      if (got.send_valid !== want.send_valid) bad = {bad, " send_valid"};
      if (got.flags !== want.flags) bad = {bad, " out_flags"};
      if (got.seq !== want.seq) bad = {bad, " out_seq"};
      if (got.ack !== want.ack) bad = {bad, " out_ack"};
      if (got.dst_port !== want.dst_port) bad = {bad, " out_dst_port"};
      if (got.conn_state !== want.conn_state) bad = {bad, " conn_state"};
      if (got.became_established !== want.became_established)
        bad = {bad, " became_established"};
    end
    if (bad != "") begin
      if (mismatches < 10) begin
        $display("%0t mismatch:%s", $time, bad);
        $display("  exp v=%0b fl=%0d seq=%h ack=%h dst=%h st=%0d est=%0b",
                 want.send_valid, want.flags, want.seq, want.ack, want.dst_port,
                 want.conn_state, want.became_established);
        $display("  got v=%0b fl=%0d seq=%h ack=%h dst=%h st=%0d est=%0b",
                 got.send_valid, got.flags, got.seq, got.ack, got.dst_port,
                 got.conn_state, got.became_established);
      end
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 300;
  localparam int PhaseBeats = 330;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PortW-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       action = '0;
  logic [FlagW-1:0] seg_flags = '0;
  logic [SeqW-1:0]  seg_seq = '0;
  logic [SeqW-1:0]  seg_ack = '0;
  logic [PortW-1:0] peer_port = '0;
  logic [SeqW-1:0]  new_isn = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             send_valid;
  logic [FlagW-1:0] out_flags;
  logic [SeqW-1:0]  out_seq;
  logic [SeqW-1:0]  out_ack;
  logic [PortW-1:0] out_dst_port;
  logic [2:0]       conn_state;
  logic             became_established;

  handshake_tracker tracker;
  bit               tx_steady = 1'b0;
  bit               hold_req = 1'b0;
  int               beats_offered = 0;

  tcp_handshake_engine_top dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .seg_flags          (seg_flags),
    .seg_seq            (seg_seq),
    .seg_ack            (seg_ack),
    .peer_port          (peer_port),
    .new_isn            (new_isn),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .send_valid         (send_valid),
    .out_flags          (out_flags),
    .out_seq            (out_seq),
    .out_ack            (out_ack),
    .out_dst_port       (out_dst_port),
    .conn_state         (conn_state),
    .became_established (became_established)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // beat monitor
  always @(posedge clk) begin
    item_t   beat;
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_src_port(cfg_data);
      if (in_valid && !in_stall) begin
        beat.action    = action_t'(action);
        beat.seg_flags = seg_flags;
        beat.seg_seq   = seg_seq;
        beat.seg_ack   = seg_ack;
        beat.peer_port = peer_port;
        beat.new_isn   = new_isn;
        tracker.note_item(beat);
      end
      if (out_valid && !out_stall) begin
        got.send_valid         = send_valid;
        got.flags              = out_flags;
        got.seq                = out_seq;
        got.ack                = out_ack;
        got.dst_port           = out_dst_port;
        got.conn_state         = phase_t'(conn_state);
        got.became_established = became_established;
        tracker.check_result(got);
      end
    end
  end

  // receiver backpressure
  initial begin
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("** tcp_handshake_engine_top: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // sequence numbers biased toward the wrap point
  function automatic logic [SeqW-1:0] pick_num();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
    if (r < 25) return 32'($urandom_range(0, 2));
    return $urandom;
  endfunction

  function automatic item_t mk(action_t a, logic [FlagW-1:0] fl, logic [SeqW-1:0] sq,
                               logic [SeqW-1:0] ak, logic [PortW-1:0] pt,
                               logic [SeqW-1:0] isn);
    item_t it;
    it.action    = a;
    it.seg_flags = fl;
    it.seg_seq   = sq;
    it.seg_ack   = ak;
    it.peer_port = pt;
    it.new_isn   = isn;
    return it;
  endfunction

  function automatic item_t noise();
    return mk(action_t'($urandom_range(0, 3)), 2'($urandom), $urandom, $urandom,
              16'($urandom), $urandom);
  endfunction

  function automatic item_t tick();
    return mk(ACT_TIMEOUT, 2'($urandom), $urandom, $urandom, 16'($urandom), $urandom);
  endfunction

  task automatic offer_beat(item_t it);
    int gap;
    in_valid  <= 1'b1;
    action    <= it.action;
    seg_flags <= it.seg_flags;
    seg_seq   <= it.seg_seq;
    seg_ack   <= it.seg_ack;
    peer_port <= it.peer_port;
    new_isn   <= it.new_isn;
    do @(posedge clk); while (in_stall);
    beats_offered++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.backlog() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_port(logic [PortW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic server_session();
    logic [SeqW-1:0]  isn;
    logic [SeqW-1:0]  pseq;
    logic [PortW-1:0] pp;
    isn  = pick_num();
    pseq = pick_num();
    pp   = 16'($urandom);
    offer_beat(mk(ACT_LISTEN, 2'($urandom), $urandom, $urandom, 16'($urandom), $urandom));
    if ($urandom_range(0, 9) == 0)
      offer_beat(mk(ACT_SEGMENT, FlAck, $urandom, $urandom, pp, $urandom));
    offer_beat(mk(ACT_SEGMENT, FlSyn, pseq, $urandom, pp, isn));
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: offer_beat(tick());
        1: offer_beat(mk(ACT_SEGMENT, FlSyn, pseq, $urandom, 16'($urandom), $urandom));
        2: offer_beat(mk(ACT_SEGMENT, FlSyn, pseq ^ (32'd1 << $urandom_range(0, 31)),
                         $urandom, pp, $urandom));
        3: offer_beat(mk(ACT_SEGMENT, FlAck, pseq + 32'd1,
                         isn + 32'd1 + 32'($urandom_range(1, 3)), pp, $urandom));
        default: offer_beat(mk(ACT_SEGMENT, FlAck, pseq + 32'd2, isn + 32'd1, pp, $urandom));
      endcase
    end
    if ($urandom_range(0, 9) < 8)
      offer_beat(mk(ACT_SEGMENT, FlAck, pseq + 32'd1, isn + 32'd1, pp, $urandom));
    if ($urandom_range(0, 3) == 0) offer_beat(noise());
  endtask

  task automatic client_session();
    logic [SeqW-1:0]  isn;
    logic [SeqW-1:0]  pseq;
    logic [PortW-1:0] pp;
    isn  = pick_num();
    pseq = pick_num();
    pp   = 16'($urandom);
    offer_beat(mk(ACT_CONNECT, 2'($urandom), $urandom, $urandom, pp, isn));
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: offer_beat(tick());
        1: offer_beat(mk(ACT_SEGMENT, FlSynAck, pseq,
                         isn + 32'd1 + 32'($urandom_range(1, 3)), pp, $urandom));
        2: offer_beat(mk(ACT_SEGMENT, FlAck, $urandom, isn + 32'd1, pp, $urandom));
        default: offer_beat(mk(ACT_SEGMENT, FlSyn, pseq, isn + 32'd1, pp, $urandom));
      endcase
    end
    if ($urandom_range(0, 19) < 17) begin
      offer_beat(mk(ACT_SEGMENT, FlSynAck, pseq, isn + 32'd1, 16'($urandom), $urandom));
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 3))
          0: offer_beat(tick());
          1: offer_beat(mk(ACT_SEGMENT, FlSynAck, pseq ^ (32'd1 << $urandom_range(0, 31)),
                           isn + 32'd1, pp, $urandom));
          default: offer_beat(mk(ACT_SEGMENT, FlSynAck, pseq, isn + 32'd1, pp, $urandom));
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0) offer_beat(noise());
  endtask

  task automatic run_sessions(int goal);
    int r;
    goal = beats_offered + goal;
    while (beats_offered < goal) begin
      r = $urandom_range(0, 99);
      if (r < 42) server_session();
      else if (r < 84) client_session();
      else offer_beat(noise());
    end
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_port(16'h0000);

    // directed: closed phase, client path with wrap, server path with wrap
    offer_beat(mk(ACT_SEGMENT, FlSyn, '0, '0, '0, '0));
    offer_beat(mk(ACT_TIMEOUT, FlNone, '0, '0, '0, '0));
    offer_beat(mk(ACT_CONNECT, FlNone, '0, '0, 16'hFFFF, 32'hFFFF_FFFF));
    offer_beat(mk(ACT_TIMEOUT, FlSynAck, '1, '1, '1, '1));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, 32'd5, 32'd1, 16'hFFFF, '0));
    offer_beat(mk(ACT_SEGMENT, FlAck, '1, '0, 16'hFFFF, '0));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, 32'hFFFF_FFFF, '0, 16'h0000, '1));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, 32'hFFFF_FFFF, '0, 16'h1234, '0));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, '0, '0, 16'hFFFF, '0));
    offer_beat(mk(ACT_TIMEOUT, FlNone, '0, '0, '0, '0));
    offer_beat(mk(ACT_SEGMENT, FlNone, 32'hFFFF_FFFF, '0, 16'hFFFF, '0));
    offer_beat(mk(ACT_LISTEN, FlSynAck, '1, '1, '1, '1));
    offer_beat(mk(ACT_SEGMENT, FlAck, '1, '1, '1, '1));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, '1, '1, '1, '1));
    offer_beat(mk(ACT_SEGMENT, FlSyn, 32'hFFFF_FFFF, '1, 16'h0000, '0));
    offer_beat(mk(ACT_SEGMENT, FlSyn, 32'hFFFF_FFFF, '0, 16'hFFFF, '1));
    offer_beat(mk(ACT_SEGMENT, FlSyn, 32'd1, '0, 16'h0000, '0));
    offer_beat(mk(ACT_TIMEOUT, FlNone, '0, '0, '0, '0));
    offer_beat(mk(ACT_SEGMENT, FlAck, '0, 32'd2, 16'h0000, '0));
    offer_beat(mk(ACT_SEGMENT, FlAck, 32'd1, 32'd1, 16'h0000, '0));
    offer_beat(mk(ACT_SEGMENT, FlSynAck, '0, 32'd1, 16'h0000, '0));
    offer_beat(mk(ACT_SEGMENT, FlAck, '0, 32'd1, 16'h0000, '0));
    offer_beat(mk(ACT_CONNECT, FlNone, '0, '0, 16'h1234, 32'h8000_0000));
    offer_beat(mk(ACT_LISTEN, FlNone, '0, '0, '0, '0));
    drain();
    write_port(16'hFFFF);

    for (int p = 0; p < 4; p++) begin
      tx_steady = (p == 1);
      if (p == 2) hold_req = 1'b1;
      run_sessions(PhaseBeats);
      drain();
      write_port(p == 3 ? LocalPortReset : 16'($urandom));
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.backlog() == 0)
      $display("** tcp_handshake_engine_top: PASSED **");
    else
      $display("** tcp_handshake_engine_top: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/tcph_pkg.sv
sv/tcph_step.sv
sv/tcp_handshake_engine_top.sv
tb/sv/tb_top.sv
